@@ sv/jsv_pkg.sv @@
// Package: shared types and constants for the JSON stream validator.
`default_nettype none
package jsv_pkg;
    localparam int MAX_DEPTH_DEF = 256;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_doc;
    } jsv_in_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [8:0] open_levels;
    } jsv_out_t;

    localparam logic [1:0] VERDICT_SCAN   = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] VERDICT_REJECT = 2'd2;
endpackage
`default_nettype wire

@@ sv/json_stream_validator_unit.sv @@
// Top level: streaming strict JSON syntax and UTF-8 validator.
`default_nettype none
// One document byte enters per word on the s_ channel, and one status word leaves per byte on
// the m_ channel: verdict (0 scanning, 1 accepted on the last byte, 2 rejected) and the count
// of open containers. A byte is accepted every cycle unless the output stalls; its result is
// registered in m_data, and a new byte is taken while m_data drains. All parsing state and the
// top-of-stack container kind update together. Container kinds sit in a small memory
// with a separately registered top-of-stack bit, so a push or pop needs no read latency.
// Rejection is sticky until the byte marked end_of_doc, after which a new document starts.
module json_stream_validator_unit #(
    parameter int MAX_DEPTH = jsv_pkg::MAX_DEPTH_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire jsv_pkg::jsv_in_t  s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output jsv_pkg::jsv_out_t    m_data
);
    import jsv_pkg::*;

    localparam int LW = $clog2(MAX_DEPTH + 2);
    localparam int AW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [4:0] {
        M_START, M_ROOT, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_VALUE, M_ARR_FIRST,
        M_AFTER, M_DONE, M_STR, M_ESC, M_HEX, M_SURR_BS, M_SURR_U,
        N_MINUS, N_ZERO, N_INT, N_DOT, N_FRAC, N_E, N_ESIGN, N_EXP, M_LIT
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic         is_key_reg, is_key_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic         top_reg, top_next;
    logic [1:0]   lead_reg, lead_next;
    logic [2:0]   lp_reg, lp_next;
    logic [1:0]   lk_reg, lk_next;
    logic [2:0]   hl_reg, hl_next;
    logic [15:0]  hacc_reg, hacc_next;
    logic         hsp_reg, hsp_next;
    logic [1:0]   ul_reg, ul_next;
    logic [20:0]  uacc_reg, uacc_next;
    logic [16:0]  umin_reg, umin_next;
    logic         rej_reg, rej_next;
    logic         kinds [MAX_DEPTH+1];
    logic         below_q;

    // Stack memory: write on push; the entry below top is reloaded into a register on push or pop.
    logic          push_en, pop_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic       accept;
    logic [7:0] c;
    logic       ws, dig, hexd;
    logic [3:0] hv;
    logic [20:0] uacc_new;
    logic [15:0] hacc_new;
    jsv_out_t   res;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign c       = s_data.byte_value;
    assign ws      = c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    assign dig     = c >= "0" && c <= "9";

    always_comb begin
        hexd = 1'b1;
        hv   = 4'd0;
        if (dig) hv = 4'(c - "0");
        else if (c >= "a" && c <= "f") hv = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") hv = 4'(c - "A" + 8'd10);
        else hexd = 1'b0;
    end

    function automatic logic lit_char(input logic [1:0] k, input logic [2:0] p,
                                      input logic [7:0] ch);
        logic [7:0] e;
        logic       ok;
        begin
            ok = 1'b1;
            e  = 8'd0;
            unique case (k)
                2'd1: begin
                    unique case (p)
                        3'd1: e = "a";
                        3'd2: e = "l";
                        3'd3: e = "s";
                        3'd4: e = "e";
                        default: ok = 1'b0;
                    endcase
                end
                2'd2: begin
                    unique case (p)
                        3'd1: e = "u";
                        3'd2: e = "l";
                        3'd3: e = "l";
                        default: ok = 1'b0;
                    endcase
                end
                default: begin
                    unique case (p)
                        3'd1: e = "r";
                        3'd2: e = "u";
                        3'd3: e = "e";
                        default: ok = 1'b0;
                    endcase
                end
            endcase
            lit_char = ok && ch == e;
        end
    endfunction

    assign uacc_new = {uacc_reg[14:0], c[5:0]};
    assign hacc_new = {hacc_reg[11:0], hv};

    always_comb begin
        logic again, go, do_push, do_close, kind, is_val;
        mode_next = mode_reg; is_key_next = is_key_reg; lvl_next = lvl_reg;
        top_next = top_reg; lead_next = lead_reg; lp_next = lp_reg; lk_next = lk_reg;
        hl_next = hl_reg; hacc_next = hacc_reg; hsp_next = hsp_reg; ul_next = ul_reg;
        uacc_next = uacc_reg; umin_next = umin_reg; rej_next = rej_reg;
        push_en = 1'b0; pop_en = 1'b0;
        again = 1'b0; do_push = 1'b0; do_close = 1'b0; kind = 1'b1; is_val = 1'b0;
        // number ending re-feeds the byte in M_AFTER; unrolled as a second pass
        for (int pass = 0; pass < 2; pass++) begin
            go = (pass == 0) ? !rej_reg : again;
            again = 1'b0;
            if (go && !rej_next) begin
                unique case (mode_next)
                    M_START: begin
                        if (lead_next == 2'd0) begin
                            if (c == 8'hEF) lead_next = 2'd1;
                            else if (ws) mode_next = M_ROOT;
                            else if (c == "{") begin do_push = 1'b1; kind = 1'b1; end
                            else rej_next = 1'b1;
                        end else if (lead_next == 2'd1) begin
                            if (c == 8'hBB) lead_next = 2'd2; else rej_next = 1'b1;
                        end else begin
                            if (c == 8'hBF) mode_next = M_ROOT; else rej_next = 1'b1;
                        end
                    end
                    M_ROOT: begin
                        if (c == "{") begin do_push = 1'b1; kind = 1'b1; end
                        else if (!ws) rej_next = 1'b1;
                    end
                    M_OBJ_FIRST, M_OBJ_KEY: begin
                        if (ws) begin end
                        else if (c == 8'h22) begin mode_next = M_STR; is_key_next = 1'b1; end
                        else if (c == "}" && mode_next == M_OBJ_FIRST) do_close = 1'b1;
                        else rej_next = 1'b1;
                    end
                    M_COLON: begin
                        if (c == ":") mode_next = M_VALUE;
                        else if (!ws) rej_next = 1'b1;
                    end
                    M_VALUE, M_ARR_FIRST: begin
                        if (ws) begin end
                        else if (c == "]" && mode_next == M_ARR_FIRST) do_close = 1'b1;
                        else is_val = 1'b1;
                    end
                    M_AFTER: begin
                        if (ws) begin end
                        else if (c == ",") mode_next = top_next ? M_OBJ_KEY : M_VALUE;
                        else if (c == "}" || c == "]") do_close = 1'b1;
                        else rej_next = 1'b1;
                    end
                    M_DONE: if (!ws) rej_next = 1'b1;
                    M_STR: begin
                        if (ul_next != 2'd0) begin
                            if (c[7:6] != 2'b10) rej_next = 1'b1;
                            else begin
                                uacc_next = uacc_new;
                                ul_next   = ul_next - 2'd1;
                                if (ul_next == 2'd0 && (uacc_new < 21'(umin_next)
                                        || uacc_new > 21'h10FFFF
                                        || (uacc_new >= 21'hD800 && uacc_new <= 21'hDFFF)))
                                    rej_next = 1'b1;
                            end
                        end else if (c == 8'h22) mode_next = is_key_next ? M_COLON : M_AFTER;
                        else if (c < 8'h20) rej_next = 1'b1;
                        else if (c == 8'h5C) mode_next = M_ESC;
                        else if (c < 8'h80) begin end
                        else if (c[7:5] == 3'b110) begin
                            ul_next = 2'd1; uacc_next = 21'(c[4:0]); umin_next = 17'h80;
                        end else if (c[7:4] == 4'b1110) begin
                            ul_next = 2'd2; uacc_next = 21'(c[3:0]); umin_next = 17'h800;
                        end else if (c[7:3] == 5'b11110) begin
                            ul_next = 2'd3; uacc_next = 21'(c[2:0]); umin_next = 17'h10000;
                        end else rej_next = 1'b1;
                    end
                    M_ESC: begin
                        if (c == 8'h22 || c == 8'h5C || c == "/" || c == "b" || c == "f"
                            || c == "n" || c == "r" || c == "t") mode_next = M_STR;
                        else if (c == "u") begin
                            mode_next = M_HEX; hl_next = 3'd4; hacc_next = 16'd0;
                        end else rej_next = 1'b1;
                    end
                    M_HEX: begin
                        if (!hexd) rej_next = 1'b1;
                        else begin
                            hacc_next = hacc_new;
                            if (hl_next != 3'd0) hl_next = hl_next - 3'd1;
                            if (hl_next == 3'd0) begin
                                if (hsp_next) begin
                                    hsp_next = 1'b0;
                                    if (hacc_new < 16'hDC00 || hacc_new > 16'hDFFF)
                                        rej_next = 1'b1;
                                    else mode_next = M_STR;
                                end else if (hacc_new >= 16'hD800 && hacc_new <= 16'hDBFF) begin
                                    hsp_next = 1'b1; mode_next = M_SURR_BS;
                                end else if (hacc_new >= 16'hDC00 && hacc_new <= 16'hDFFF)
                                    rej_next = 1'b1;
                                else mode_next = M_STR;
                            end
                        end
                    end
                    M_SURR_BS: if (c == 8'h5C) mode_next = M_SURR_U; else rej_next = 1'b1;
                    M_SURR_U: begin
                        if (c == "u") begin
                            mode_next = M_HEX; hl_next = 3'd4; hacc_next = 16'd0;
                        end else rej_next = 1'b1;
                    end
                    N_MINUS: begin
                        if (c == "0") mode_next = N_ZERO;
                        else if (dig) mode_next = N_INT;
                        else rej_next = 1'b1;
                    end
                    N_ZERO, N_INT: begin
                        if (dig) begin if (mode_next == N_ZERO) rej_next = 1'b1; end
                        else if (c == ".") mode_next = N_DOT;
                        else if (c == "e" || c == "E") mode_next = N_E;
                        else begin mode_next = M_AFTER; again = 1'b1; end
                    end
                    N_DOT: if (dig) mode_next = N_FRAC; else rej_next = 1'b1;
                    N_FRAC: begin
                        if (dig) begin end
                        else if (c == "e" || c == "E") mode_next = N_E;
                        else begin mode_next = M_AFTER; again = 1'b1; end
                    end
                    N_E: begin
                        if (c == "+" || c == "-") mode_next = N_ESIGN;
                        else if (dig) mode_next = N_EXP;
                        else rej_next = 1'b1;
                    end
                    N_ESIGN: if (dig) mode_next = N_EXP; else rej_next = 1'b1;
                    N_EXP: if (!dig) begin mode_next = M_AFTER; again = 1'b1; end
                    M_LIT: begin
                        if (!lit_char(lk_next, lp_next, c)) rej_next = 1'b1;
                        else begin
                            lp_next = lp_next + 3'd1;
                            if ((lk_next == 2'd1 && lp_next == 3'd5)
                                || (lk_next != 2'd1 && lp_next == 3'd4)) mode_next = M_AFTER;
                        end
                    end
                    default: rej_next = 1'b1;
                endcase
            end
        end
        if (is_val) begin
            if (lvl_reg > LW'(MAX_DEPTH)) rej_next = 1'b1;
            else if (c == "{") begin do_push = 1'b1; kind = 1'b1; end
            else if (c == "[") begin do_push = 1'b1; kind = 1'b0; end
            else if (c == 8'h22) begin mode_next = M_STR; is_key_next = 1'b0; end
            else if (c == "t" || c == "f" || c == "n") begin
                lk_next = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
                lp_next = 3'd1; mode_next = M_LIT;
            end else if (c == "-") mode_next = N_MINUS;
            else if (c == "0") mode_next = N_ZERO;
            else if (dig) mode_next = N_INT;
            else rej_next = 1'b1;
        end
        if (do_push) begin
            if (lvl_reg > LW'(MAX_DEPTH)) rej_next = 1'b1;
            else begin
                push_en   = 1'b1;
                top_next  = kind;
                lvl_next  = lvl_reg + 1'b1;
                mode_next = kind ? M_OBJ_FIRST : M_ARR_FIRST;
            end
        end
        if (do_close) begin
            // a close only happens with levels open: every mode reaching it is inside one
            if (lvl_next == '0 || !((c == "}" && top_next) || (c == "]" && !top_next)))
                rej_next = 1'b1;
            else begin
                pop_en    = 1'b1;
                lvl_next  = lvl_next - 1'b1;
                top_next  = below_q;
                mode_next = (lvl_next != '0) ? M_AFTER : M_DONE;
            end
        end
    end

    // Entry just below top lives in a register refreshed on every push/pop.
    // After a pop the new entry below top sits three below the current count.
    assign wr_addr = AW'(lvl_reg);
    assign rd_addr = (lvl_reg >= LW'(3)) ? AW'(lvl_reg - LW'(3)) : '0;

    always_ff @(posedge aclk) begin
        if (accept && push_en) kinds[wr_addr] <= top_next;
        if (accept && push_en) below_q <= top_reg;
        else if (accept && pop_en) below_q <= kinds[rd_addr];
    end

    always_comb begin
        res.open_levels = 9'(lvl_next);
        if (rej_next) res.verdict = VERDICT_REJECT;
        else if (s_data.end_of_doc)
            res.verdict = (mode_next == M_DONE) ? VERDICT_ACCEPT : VERDICT_REJECT;
        else res.verdict = VERDICT_SCAN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_START; is_key_reg <= 1'b0; lvl_reg <= '0; top_reg <= 1'b1;
            lead_reg <= '0; lp_reg <= '0; lk_reg <= '0; hl_reg <= '0; hacc_reg <= '0;
            hsp_reg <= 1'b0; ul_reg <= '0; uacc_reg <= '0; umin_reg <= '0; rej_reg <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (m_ready) m_valid <= 1'b0;
            if (accept) begin
                m_valid <= 1'b1;
                m_data  <= res;
                if (s_data.end_of_doc) begin
                    mode_reg <= M_START; is_key_reg <= 1'b0; lvl_reg <= '0; top_reg <= 1'b1;
                    lead_reg <= '0; lp_reg <= '0; lk_reg <= '0; hl_reg <= '0;
                    hacc_reg <= '0; hsp_reg <= 1'b0; ul_reg <= '0; uacc_reg <= '0;
                    umin_reg <= '0; rej_reg <= 1'b0;
                end else begin
                    mode_reg <= mode_next; is_key_reg <= is_key_next; lvl_reg <= lvl_next;
                    top_reg <= top_next; lead_reg <= lead_next; lp_reg <= lp_next;
                    lk_reg <= lk_next; hl_reg <= hl_next; hacc_reg <= hacc_next;
                    hsp_reg <= hsp_next; ul_reg <= ul_next; uacc_reg <= uacc_next;
                    umin_reg <= umin_next; rej_reg <= rej_next;
                end
            end
        end
    end

    // Checks
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LW'(MAX_DEPTH + 1)) else $error("depth overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result lost");
    a_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.verdict != 2'd3) else $error("bad verdict");
endmodule
`default_nettype wire
